// ----- hw/rtl/hpt_pkg.sv -----
// Shared types, widths and matrix entry selection for the homogeneous point transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int CW         = 32;               // coordinate width
  localparam int PW         = 2 * CW;           // product width
  localparam int HW         = PW + 2;           // column sum width, signed
  localparam int QW         = CW;               // quotient bits computed
  localparam int NREG       = 8;
  localparam int CIDX_W     = 4;                // one spare bit so stray indexes are seen
  localparam int MAC_LAT    = 2;
  localparam int DIV_LAT    = QW + 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [NREG-1:0][63:0] mat_t;
  typedef logic [HW-1:0] mag_t;

  localparam logic [63:0] RST_R0 = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RST_R2 = 64'h0001_0000_0000_0000;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic w_zero;
  } side_t;

  function automatic coord_t mat_entry(input mat_t m, input int r, input int c);
    logic [63:0] reg_v;
    reg_v = m[r*2 + c/2];
    return (c % 2 == 1) ? coord_t'(reg_v[63:32]) : coord_t'(reg_v[31:0]);
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/homogeneous_point_transform.sv -----
// Top level: config registers, matrix pipeline, three dividers and the saturating output.
// Depends on hpt_pkg, hpt_mac and hpt_div.
// Stages: 2 multiply/sum, 1 sign prep, 33 divider stages, 1 output register;
// the first stage loads at the accepting edge.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// Reset (synchronous, rst_n low) clears all valid bits and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hpt_pkg::coord_t            in_point_x,
  input  wire hpt_pkg::coord_t            in_point_y,
  input  wire hpt_pkg::coord_t            in_point_z,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output hpt_pkg::coord_t                 out_x,
  output hpt_pkg::coord_t                 out_y,
  output hpt_pkg::coord_t                 out_z,
  output logic                            out_w_zero,
  output logic                            out_saturated,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [hpt_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [63:0]                cfg_data
);
  import hpt_pkg::*;

  localparam int VLEN = MAC_LAT + 1 + DIV_LAT;

  mat_t              mat_r;
  logic              en;
  logic [VLEN-1:0]   v_r;
  logic signed [HW-1:0] h0, h1, h2, h3;
  mag_t              ax_r, ay_r, az_r, aw_r;
  side_t             side_r [DIV_LAT+1];
  logic [QW-1:0]     qx, qy, qz;
  logic              ox, oy, oz;
  coord_t            x_nxt, y_nxt, z_nxt;
  logic              sat_nxt;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= {RST_R2, 64'd0, RST_R0, 64'd0, 64'd0, RST_R2, 64'd0, RST_R0};
    end else if (cfg_valid && cfg_index < CIDX_W'(NREG)) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[VLEN-2:0], in_valid};
      out_valid <= v_r[VLEN-1];
    end
  end

  hpt_mac u_mac (
    .clk (clk), .en (en),
    .px (in_point_x), .py (in_point_y), .pz (in_point_z),
    .mat (mat_r),
    .h0 (h0), .h1 (h1), .h2 (h2), .h3 (h3)
  );

  // Split signs from magnitudes ahead of the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= h0[HW-1] ? mag_t'(-h0) : mag_t'(h0);
      ay_r <= h1[HW-1] ? mag_t'(-h1) : mag_t'(h1);
      az_r <= h2[HW-1] ? mag_t'(-h2) : mag_t'(h2);
      aw_r <= h3[HW-1] ? mag_t'(-h3) : mag_t'(h3);
      side_r[0] <= '{neg_x:  h0[HW-1] ^ h3[HW-1],
                     neg_y:  h1[HW-1] ^ h3[HW-1],
                     neg_z:  h2[HW-1] ^ h3[HW-1],
                     w_zero: h3 == '0};
    end
  end

  for (genvar k = 1; k <= DIV_LAT; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  hpt_div u_div_x (.clk (clk), .en (en), .num (ax_r), .den (aw_r), .quot (qx), .ovf (ox));
  hpt_div u_div_y (.clk (clk), .en (en), .num (ay_r), .den (aw_r), .quot (qy), .ovf (oy));
  hpt_div u_div_z (.clk (clk), .en (en), .num (az_r), .den (aw_r), .quot (qz), .ovf (oz));

  function automatic logic [CW:0] clamp(input logic [QW-1:0] q, input logic o,
                                        input logic neg);
    logic [QW-1:0] lim;
    logic          s;
    logic [QW-1:0] mag;
    lim = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    s   = o || (q > lim);
    mag = s ? lim : q;
    return {s, neg ? -mag : mag};
  endfunction

  always_comb begin
    logic [CW:0] rx, ry, rz;
    rx = clamp(qx, ox, side_r[DIV_LAT].neg_x);
    ry = clamp(qy, oy, side_r[DIV_LAT].neg_y);
    rz = clamp(qz, oz, side_r[DIV_LAT].neg_z);
    if (side_r[DIV_LAT].w_zero) begin
      x_nxt   = '0;
      y_nxt   = '0;
      z_nxt   = '0;
      sat_nxt = 1'b0;
    end else begin
      x_nxt   = coord_t'(rx[CW-1:0]);
      y_nxt   = coord_t'(ry[CW-1:0]);
      z_nxt   = coord_t'(rz[CW-1:0]);
      sat_nxt = rx[CW] || ry[CW] || rz[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x         <= x_nxt;
      out_y         <= y_nxt;
      out_z         <= z_nxt;
      out_w_zero    <= side_r[DIV_LAT].w_zero;
      out_saturated <= sat_nxt;
    end
  end

  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !out_saturated)
    else $error("w_zero result carries nonzero data");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[VLEN-1] |=> out_valid)
    else $error("item lost at output stage");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
      out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000 ||
      out_z == 32'sh7FFF_FFFF || out_z == 32'sh8000_0000)
    else $error("saturated flag without clamped coordinate");
endmodule
`default_nettype wire

// ----- hw/rtl/hpt_mac.sv -----
// Matrix multiply pipeline: twelve products in stage one, four column sums in stage two.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpt_mac (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire hpt_pkg::coord_t px,
  input  wire hpt_pkg::coord_t py,
  input  wire hpt_pkg::coord_t pz,
  input  wire hpt_pkg::mat_t   mat,
  output logic signed [hpt_pkg::HW-1:0] h0,
  output logic signed [hpt_pkg::HW-1:0] h1,
  output logic signed [hpt_pkg::HW-1:0] h2,
  output logic signed [hpt_pkg::HW-1:0] h3
);
  import hpt_pkg::*;

  logic signed [PW-1:0] prod_r [4][3];
  logic signed [CW-1:0] bias_r [4];
  logic signed [HW-1:0] h_r    [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        prod_r[c][0] <= PW'(px * mat_entry(mat, 0, c));
        prod_r[c][1] <= PW'(py * mat_entry(mat, 1, c));
        prod_r[c][2] <= PW'(pz * mat_entry(mat, 2, c));
        bias_r[c]    <= mat_entry(mat, 3, c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        h_r[c] <= HW'(prod_r[c][0]) + HW'(prod_r[c][1]) + HW'(prod_r[c][2])
                + (HW'(bias_r[c]) <<< FRAC_BITS);
      end
    end
  end

  assign h0 = h_r[0];
  assign h1 = h_r[1];
  assign h2 = h_r[2];
  assign h3 = h_r[3];
endmodule
`default_nettype wire

// ----- hw/rtl/hpt_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, with overflow detect up front.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpt_div (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire hpt_pkg::mag_t     num,
  input  wire hpt_pkg::mag_t     den,
  output logic [hpt_pkg::QW-1:0] quot,
  output logic                   ovf
);
  import hpt_pkg::*;

  localparam int NW = HW + FRAC_BITS + QW;

  logic [HW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [HW-1:0] d_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [NW-1:0] num_sh;

  assign num_sh = NW'(num) << FRAC_BITS;

  // Quotient fits in QW bits only when the top part is below the divisor.
  // Without overflow the top part is below the divisor, so its low HW bits hold it exactly.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_sh[QW+HW-1:QW];
      lo_r[0]  <= num_sh[QW-1:0];
      d_r[0]   <= den;
      ovf_r[0] <= num_sh[NW-1:QW] >= den;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [HW:0] trial;
    logic        ge;
    logic [HW:0] diff;
    assign trial = {rem_r[k-1], lo_r[k-1][QW-1]};
    assign ge    = trial >= {1'b0, d_r[k-1]};
    assign diff  = trial - {1'b0, d_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[HW-1:0] : trial[HW-1:0];
        lo_r[k]  <= {lo_r[k-1][QW-2:0], ge};
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quot = lo_r[QW];
  assign ovf  = ovf_r[QW];
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking bench for homogeneous_point_transform: drives points through a
// configured 4x4 matrix and checks projected results against an exact predictor.
// Depends on hpt_pkg and the block's RTL only.
`timescale 1ns / 1ps
module testbench;
  import hpt_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int NUM_RANDOM = 530;
  localparam int SETTLE = 60;

  typedef enum logic [CIDX_W-1:0] {
    R0C01 = 0, R0C23 = 1, R1C01 = 2, R1C23 = 3,
    R2C01 = 4, R2C23 = 5, R3C01 = 6, R3C23 = 7, BAD_IDX = 9
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } proj_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        chk;   // typed-in expectation present
    proj_t       exp;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic in_ready, out_valid, cfg_ready, out_w_zero, out_saturated;
  coord_t in_point_x = '0, in_point_y = '0, in_point_z = '0;
  coord_t out_x, out_y, out_z;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] matrix [8];
  proj_t expected_q[$];
  int mismatches = 0, n_results = 0, n_sat = 0, n_wz = 0;
  bit quiet_out = 0;
  bit in_busy_idle = 1;

  always #5 clk = ~clk;

  homogeneous_point_transform DUT (.*);

  function automatic logic signed [31:0] m_at(int r, int c);
    logic [63:0] v;
    v = matrix[r*2 + c/2];
    return c % 2 ? v[63:32] : v[31:0];
  endfunction

  // exact column sums, then truncating divide with clamp
  function automatic proj_t project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic signed [127:0] h [4];
    logic signed [127:0] n, d, q;
    logic signed [127:0] lim;
    proj_t r;
    logic [31:0] o [3];
    r = '0;
    for (int c = 0; c < 4; c++) begin
      h[c] = (128'(m_at(3, c)) <<< FB)
           + 128'(signed'(px)) * 128'(m_at(0, c))
           + 128'(signed'(py)) * 128'(m_at(1, c))
           + 128'(signed'(pz)) * 128'(m_at(2, c));
    end
    if (h[3] == 0) begin
      r.wz = 1;
      return r;
    end
    d = h[3];
    for (int c = 0; c < 3; c++) begin
      n = h[c] <<< FB;
      q = n / d;  // truncates toward zero
      if (q > 128'sd2147483647) begin
        q = 128'sd2147483647; r.sat = 1;
      end else if (q < -128'sd2147483648) begin
        q = -128'sd2147483648; r.sat = 1;
      end
      o[c] = q[31:0];
    end
    r.x = o[0]; r.y = o[1]; r.z = o[2];
    return r;
  endfunction

  task automatic wait_idle();
    in_valid <= 0;
    cfg_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; the next phase drops it
  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < 8) matrix[idx] = val;
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit chk, proj_t typed);
    proj_t p;
    cfg_valid <= 0;
    if (in_busy_idle && $urandom_range(99) < 15) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 15);
    end
    in_valid <= 1; in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    do @(posedge clk); while (!in_ready);
    p = project(px, py, pz);
    if (chk && p !== typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("typed row disagrees with predictor: %h vs %h", typed, p);
    end
    expected_q.push_back(chk ? typed : p);
  endtask

  // result side: random stall, compare on handshake
  always @(posedge clk) begin
    proj_t got, want;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_x, out_y, out_z, out_w_zero, out_saturated};
        n_results++;
        n_sat += out_saturated;
        n_wz += out_w_zero;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%h y=%h z=%h wz=%b sat=%b  got x=%h y=%h z=%h wz=%b sat=%b",
                       want.x, want.y, want.z, want.wz, want.sat,
                       got.x, got.y, got.z, got.wz, got.sat);
          end
        end
      end
      out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 8)) << $urandom_range(12, 20);
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {{12{1'b0}}, 20'($urandom)} ^ {32{$urandom_range(1) == 1}};
    endcase
  endfunction

  function automatic logic [31:0] rnd_entry();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'sd0;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'(signed'($urandom_range(0, 8) - 4)) <<< 16;
    endcase
  endfunction

  row_t plan [$];

  initial begin
    proj_t none;
    none = '0;
    matrix = '{64'h0000_0000_0001_0000, 0, 64'h0001_0000_0000_0000, 0,
               0, 64'h0000_0000_0001_0000, 0, 64'h0001_0000_0000_0000};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // identity after reset: points come back unchanged
    plan.push_back('{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 1,
                     '{32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 0, 0}});
    plan.push_back('{0, 0, 0, 1, '{0, 0, 0, 0, 0}});
    plan.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1,
                     '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0}});
    plan.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1,
                     '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0}});
    foreach (plan[i]) send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].chk, plan[i].exp);
    wait_idle();

    // w taken from z: zero z gives the zero-w flag, small z saturates
    write_reg(R3C23, 64'h0);
    write_reg(R2C23, 64'h0001_0000_0001_0000);
    write_reg(BAD_IDX, 64'hDEAD_BEEF_DEAD_BEEF);   // ignored
    plan.delete();
    plan.push_back('{32'h0005_0000, 32'h0003_0000, 32'h0, 1, '{0, 0, 0, 1, 0}});
    plan.push_back('{32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 1,
                     '{32'h7FFF_FFFF, 0, 32'h0001_0000, 0, 1}});
    plan.push_back('{32'h8000_0000, 32'h0, 32'h0000_0001, 1,
                     '{32'h8000_0000, 0, 32'h0001_0000, 0, 1}});
    plan.push_back('{32'h0004_0000, 32'hFFFC_0000, 32'h0002_0000, 1,
                     '{32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 0, 0}});
    plan.push_back('{32'h0001_0000, 32'h0001_0000, 32'hFFFD_0000, 0, none});
    plan.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none});
    foreach (plan[i]) send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].chk, plan[i].exp);
    wait_idle();

    // extreme, all-ones and all-zero entries in every register
    for (int r = 0; r < 8; r++) write_reg(reg_idx_e'(r), 64'h8000_0000_7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none);
    send_point(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 0, none);
    wait_idle();
    for (int r = 0; r < 8; r++) write_reg(reg_idx_e'(r), 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, none);
    wait_idle();
    for (int r = 0; r < 8; r++) write_reg(reg_idx_e'(r), 64'h0);
    send_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 0, none);
    wait_idle();

    // random phases, each with a fresh matrix; one phase runs without idling
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = 0; r < 8; r++) write_reg(reg_idx_e'(r), {rnd_entry(), rnd_entry()});
      // keep w mostly well away from zero so the divide is exercised
      if ($urandom_range(3) != 0) write_reg(R3C23, {32'(signed'($urandom_range(1, 64))) <<< 16,
                                                    rnd_entry()});
      in_busy_idle = (ph != 4);
      quiet_out = (ph == 4);
      for (int i = 0; i < NUM_RANDOM / 10; i++)
        send_point(rnd_coord(), rnd_coord(), rnd_coord(), 0, none);
      wait_idle();
    end
    in_busy_idle = 1;
    quiet_out = 0;

    $display("Covered %0d results over 15 matrix settings: %0d clamped, %0d with zero w.",
             n_results, n_sat, n_wz);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still owed", mismatches, expected_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end
endmodule
